// ===== sv/i2cm_pkg.sv =====
// i2cm_pkg: types and constants shared by the I2C master bit engine.
// No dependencies; used by i2cm_csr, i2cm_seq and i2c_master_bit_engine.
`default_nettype none

package i2cm_pkg;

   // Command codes carried in the action field
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_READ  = 3'd4,
      ACT_WACK  = 3'd5
   } action_type;

   // Bus sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_A,
      PH_START_B,
      PH_STOP_PRE,
      PH_STOP_A,
      PH_STOP_B,
      PH_WR_SET,
      PH_WR_HIGH,
      PH_WR_LOW,
      PH_RD_LOW,
      PH_RD_HIGH,
      PH_ACK_LOW,
      PH_ACK_HIGH,
      PH_WA_LOW,
      PH_WA_HIGH
   } phase_type;

   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned UNIT_W     = 16;
   localparam int unsigned POLL_W     = 8;
   localparam int unsigned UNITS_W    = 3;
   localparam int unsigned BIT_IDX_W  = 4;

   // Phase lengths in delay units
   localparam logic [UNITS_W-1:0] START_A_UNITS  = 3'd5;
   localparam logic [UNITS_W-1:0] START_B_UNITS  = 3'd6;
   localparam logic [UNITS_W-1:0] STOP_UNITS     = 3'd6;
   localparam logic [UNITS_W-1:0] WR_UNITS       = 3'd2;
   localparam logic [UNITS_W-1:0] RD_LOW_UNITS   = 3'd2;
   localparam logic [UNITS_W-1:0] RD_HIGH_UNITS  = 3'd1;
   localparam logic [UNITS_W-1:0] ACK_LOW_UNITS  = 3'd2;
   localparam logic [UNITS_W-1:0] ACK_HIGH_UNITS = 3'd5;
   localparam logic [UNITS_W-1:0] WA_UNITS       = 3'd1;

   localparam logic [UNIT_W-1:0] DELAY_UNIT_RESET = 16'd50;
   localparam logic [POLL_W-1:0] ACK_POLLS_RESET  = 8'd250;
   localparam logic [POLL_W-1:0] POLL_MAX         = 8'd255;

   // Register indexes on the configuration port
   localparam logic REG_DELAY_UNIT = 1'b0;
   localparam logic REG_ACK_POLLS  = 1'b1;

   typedef struct packed {
      logic [UNIT_W-1:0] delay_unit_ticks;
      logic [POLL_W-1:0] ack_timeout_polls;
   } cfg_type;

   typedef struct packed {
      logic [2:0]           action;
      logic [BYTE_BITS-1:0] tx_byte;
      logic                 send_ack;
      logic                 sda_in;
   } req_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 sda_drive;
      logic                 busy_res;
      logic                 done_res;
      logic [BYTE_BITS-1:0] rx_data;
      logic                 no_ack;
      logic                 rejected;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/i2cm_csr.sv =====
// i2cm_csr: APB-style register file holding delay unit and ack timeout.
// Depends on i2cm_pkg for cfg_type and register indexes.
`default_nettype none

module i2cm_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output i2cm_pkg::cfg_type     cfg
);

   logic [i2cm_pkg::UNIT_W-1:0] delay_unit_ff, delay_unit_in;
   logic [i2cm_pkg::POLL_W-1:0] ack_polls_ff, ack_polls_in;
   logic                        wr_en;
   logic                        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // Write decode
   always_comb begin
      delay_unit_in = delay_unit_ff;
      ack_polls_in  = ack_polls_ff;
      if (wr_en) begin
         unique case (reg_sel)
            i2cm_pkg::REG_DELAY_UNIT: delay_unit_in = csr_pwdata[i2cm_pkg::UNIT_W-1:0];
            i2cm_pkg::REG_ACK_POLLS:  ack_polls_in  = csr_pwdata[i2cm_pkg::POLL_W-1:0];
            default:                  delay_unit_in = delay_unit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_unit_ff <= i2cm_pkg::DELAY_UNIT_RESET;
         ack_polls_ff  <= i2cm_pkg::ACK_POLLS_RESET;
      end else begin
         delay_unit_ff <= delay_unit_in;
         ack_polls_ff  <= ack_polls_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_sel)
         i2cm_pkg::REG_DELAY_UNIT: csr_prdata = {16'd0, delay_unit_ff};
         i2cm_pkg::REG_ACK_POLLS:  csr_prdata = {24'd0, ack_polls_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   assign cfg.delay_unit_ticks  = delay_unit_ff;
   assign cfg.ack_timeout_polls = ack_polls_ff;

endmodule

`default_nettype wire

// ===== sv/i2cm_seq.sv =====
// i2cm_seq: I2C bit sequencer state and its one-tick update.
// Depends on i2cm_pkg for phase codes, phase lengths and beat structs.
`default_nettype none

module i2cm_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire i2cm_pkg::req_type req,
   input  wire i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type      rsp
);

   localparam int unsigned BB = i2cm_pkg::BYTE_BITS;

   i2cm_pkg::phase_type                phase_ff, phase_in;
   logic [i2cm_pkg::UNIT_W-1:0]        cnt_ff, cnt_in;
   logic [i2cm_pkg::UNITS_W-1:0]       units_ff, units_in;
   logic [i2cm_pkg::BIT_IDX_W-1:0]     bit_ff, bit_in;
   logic [BB-1:0]                      shift_ff, shift_in;
   logic [i2cm_pkg::POLL_W-1:0]        poll_ff, poll_in;
   logic                               scl_ff, scl_in;
   logic                               sda_ff, sda_in;
   logic                               drv_ff, drv_in;
   logic                               ack_fail_ff, ack_fail_in;
   logic [BB-1:0]                      rx_ff, rx_in;
   logic                               ack_choice_ff, ack_choice_in;

   logic                               done;
   logic                               rej;
   logic [i2cm_pkg::UNIT_W-1:0]        lim;
   logic [i2cm_pkg::UNIT_W:0]          cnt_inc;
   logic [i2cm_pkg::UNITS_W-1:0]       units_dec;
   logic [i2cm_pkg::BIT_IDX_W-1:0]     bit_inc;
   logic [i2cm_pkg::POLL_W-1:0]        poll_inc;

   // Per-tick arithmetic
   always_comb begin
      lim       = (cfg.delay_unit_ticks == '0) ? {{(i2cm_pkg::UNIT_W-1){1'b0}}, 1'b1}
                                               : cfg.delay_unit_ticks;
      cnt_inc   = {1'b0, cnt_ff} + {{i2cm_pkg::UNIT_W{1'b0}}, 1'b1};
      units_dec = (units_ff != '0) ? units_ff - 1'b1 : units_ff;
      bit_inc   = bit_ff + 1'b1;
      poll_inc  = (poll_ff < i2cm_pkg::POLL_MAX) ? poll_ff + 1'b1 : poll_ff;
   end

   // Next-state logic
   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      units_in      = units_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      poll_in       = poll_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      drv_in        = drv_ff;
      ack_fail_in   = ack_fail_ff;
      rx_in         = rx_ff;
      ack_choice_in = ack_choice_ff;
      done          = 1'b0;
      rej           = 1'b0;

      if (phase_ff != i2cm_pkg::PH_IDLE) begin
         rej = (req.action >= i2cm_pkg::ACT_START) && (req.action <= i2cm_pkg::ACT_WACK);
         if (phase_ff == i2cm_pkg::PH_STOP_PRE) begin
            scl_in   = 1'b1;
            phase_in = i2cm_pkg::PH_STOP_A;
            units_in = i2cm_pkg::STOP_UNITS;
            cnt_in   = '0;
         end else if (cnt_inc < {1'b0, lim}) begin
            cnt_in = cnt_inc[i2cm_pkg::UNIT_W-1:0];
         end else begin
            cnt_in   = '0;
            units_in = units_dec;
            if (units_dec == '0) begin
               unique case (phase_ff)
                  i2cm_pkg::PH_START_A: begin
                     sda_in   = 1'b0;
                     phase_in = i2cm_pkg::PH_START_B;
                     units_in = i2cm_pkg::START_B_UNITS;
                  end
                  i2cm_pkg::PH_START_B: begin
                     scl_in   = 1'b0;
                     phase_in = i2cm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
                  i2cm_pkg::PH_STOP_A: begin
                     sda_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_STOP_B;
                     units_in = i2cm_pkg::STOP_UNITS;
                  end
                  i2cm_pkg::PH_STOP_B: begin
                     phase_in = i2cm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
                  i2cm_pkg::PH_WR_SET: begin
                     scl_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_WR_HIGH;
                     units_in = i2cm_pkg::WR_UNITS;
                  end
                  i2cm_pkg::PH_WR_HIGH: begin
                     scl_in   = 1'b0;
                     phase_in = i2cm_pkg::PH_WR_LOW;
                     units_in = i2cm_pkg::WR_UNITS;
                  end
                  i2cm_pkg::PH_WR_LOW: begin
                     bit_in = bit_inc;
                     if (bit_inc >= i2cm_pkg::BIT_IDX_W'(BB)) begin
                        phase_in = i2cm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        sda_in   = shift_ff[BB-1];
                        shift_in = {shift_ff[BB-2:0], 1'b0};
                        phase_in = i2cm_pkg::PH_WR_SET;
                        units_in = i2cm_pkg::WR_UNITS;
                     end
                  end
                  i2cm_pkg::PH_RD_LOW: begin
                     scl_in   = 1'b1;
                     shift_in = {shift_ff[BB-2:0], req.sda_in};
                     phase_in = i2cm_pkg::PH_RD_HIGH;
                     units_in = i2cm_pkg::RD_HIGH_UNITS;
                  end
                  i2cm_pkg::PH_RD_HIGH: begin
                     bit_in = bit_inc;
                     scl_in = 1'b0;
                     if (bit_inc < i2cm_pkg::BIT_IDX_W'(BB)) begin
                        phase_in = i2cm_pkg::PH_RD_LOW;
                        units_in = i2cm_pkg::RD_LOW_UNITS;
                     end else begin
                        rx_in    = shift_ff;
                        drv_in   = 1'b1;
                        sda_in   = !ack_choice_ff;
                        phase_in = i2cm_pkg::PH_ACK_LOW;
                        units_in = i2cm_pkg::ACK_LOW_UNITS;
                     end
                  end
                  i2cm_pkg::PH_ACK_LOW: begin
                     scl_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_ACK_HIGH;
                     units_in = i2cm_pkg::ACK_HIGH_UNITS;
                  end
                  i2cm_pkg::PH_ACK_HIGH: begin
                     scl_in   = 1'b0;
                     phase_in = i2cm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
                  i2cm_pkg::PH_WA_LOW: begin
                     scl_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_WA_HIGH;
                     units_in = i2cm_pkg::WA_UNITS;
                  end
                  i2cm_pkg::PH_WA_HIGH: begin
                     if (!req.sda_in) begin
                        // slave pulled SDA low: acknowledged
                        scl_in   = 1'b0;
                        phase_in = i2cm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        poll_in = poll_inc;
                        if (poll_inc >= cfg.ack_timeout_polls) begin
                           // give up and put a stop on the bus
                           ack_fail_in = 1'b1;
                           drv_in      = 1'b1;
                           scl_in      = 1'b0;
                           sda_in      = 1'b0;
                           phase_in    = i2cm_pkg::PH_STOP_PRE;
                           units_in    = '0;
                        end else begin
                           phase_in = i2cm_pkg::PH_WA_HIGH;
                           units_in = i2cm_pkg::WA_UNITS;
                        end
                     end
                  end
                  default: begin
                     phase_in = i2cm_pkg::PH_IDLE;
                     units_in = '0;
                  end
               endcase
            end
         end
      end else begin
         // Idle: take a new command
         unique case (req.action)
            i2cm_pkg::ACT_START: begin
               drv_in   = 1'b1;
               sda_in   = 1'b1;
               scl_in   = 1'b1;
               phase_in = i2cm_pkg::PH_START_A;
               units_in = i2cm_pkg::START_A_UNITS;
               cnt_in   = '0;
            end
            i2cm_pkg::ACT_STOP: begin
               drv_in   = 1'b1;
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               phase_in = i2cm_pkg::PH_STOP_PRE;
               units_in = '0;
               cnt_in   = '0;
            end
            i2cm_pkg::ACT_WRITE: begin
               drv_in   = 1'b1;
               scl_in   = 1'b0;
               bit_in   = '0;
               sda_in   = req.tx_byte[BB-1];
               shift_in = {req.tx_byte[BB-2:0], 1'b0};
               phase_in = i2cm_pkg::PH_WR_SET;
               units_in = i2cm_pkg::WR_UNITS;
               cnt_in   = '0;
            end
            i2cm_pkg::ACT_READ: begin
               drv_in        = 1'b0;
               scl_in        = 1'b0;
               bit_in        = '0;
               shift_in      = '0;
               ack_choice_in = req.send_ack;
               phase_in      = i2cm_pkg::PH_RD_LOW;
               units_in      = i2cm_pkg::RD_LOW_UNITS;
               cnt_in        = '0;
            end
            i2cm_pkg::ACT_WACK: begin
               drv_in      = 1'b0;
               sda_in      = 1'b1;
               poll_in     = '0;
               ack_fail_in = 1'b0;
               phase_in    = i2cm_pkg::PH_WA_LOW;
               units_in    = i2cm_pkg::WA_UNITS;
               cnt_in      = '0;
            end
            default: phase_in = i2cm_pkg::PH_IDLE;
         endcase
      end
   end

   // Result beat: state after this tick
   always_comb begin
      rsp.scl_level = scl_in;
      rsp.sda_level = sda_in;
      rsp.sda_drive = drv_in;
      rsp.busy_res  = (phase_in != i2cm_pkg::PH_IDLE);
      rsp.done_res  = done;
      rsp.rx_data   = rx_in;
      rsp.no_ack    = ack_fail_in;
      rsp.rejected  = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cm_pkg::PH_IDLE;
         cnt_ff        <= '0;
         units_ff      <= '0;
         bit_ff        <= '0;
         shift_ff      <= '0;
         poll_ff       <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drv_ff        <= 1'b1;
         ack_fail_ff   <= 1'b0;
         rx_ff         <= '0;
         ack_choice_ff <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         units_ff      <= units_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         poll_ff       <= poll_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         drv_ff        <= drv_in;
         ack_fail_ff   <= ack_fail_in;
         rx_ff         <= rx_in;
         ack_choice_ff <= ack_choice_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/i2c_master_bit_engine.sv =====
// Bit-level I2C master. Every req beat is one bus tick carrying an optional command
// (none, start, stop, write byte, read byte, wait acknowledge) and the sampled SDA
// level; every tick returns exactly one rsp beat with the SCL/SDA/drive levels, busy,
// done, the last received byte, the no-ack flag and a rejected flag for commands that
// arrive while busy. One beat is taken per clock while the rsp side does not stall;
// a beat passes an input register, the sequencer update and a result register, and
// rsp_tvalid rises when the result register loads. Phase lengths count in units of
// delay_unit_ticks ticks (register 0, 0 acts as 1); the acknowledge wait gives up
// after ack_timeout_polls high polls (register 1) and then issues a stop itself.
// Depends on i2cm_pkg, i2cm_csr and i2cm_seq.
`default_nettype none

module i2c_master_bit_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   // req beat: tdata = action[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero pad
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   // rsp beat: tdata = scl_level[0], sda_level[1], sda_drive[2], busy_res[3],
   // done_res[4], rx_data[12:5], no_ack[13], rejected[14], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   i2cm_pkg::cfg_type cfg;
   i2cm_pkg::req_type req_ff, req_in;
   i2cm_pkg::rsp_type rsp_next;
   i2cm_pkg::rsp_type rsp_ff, rsp_in;
   logic              req_valid_ff, req_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              step;
   logic              req_take;

   i2cm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2cm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   // Handshake: the input register drains whenever the result register can load
   assign step       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      req_in.action   = req_tdata[2:0];
      req_in.tx_byte  = req_tdata[10:3];
      req_in.send_ack = req_tdata[11];
      req_in.sda_in   = req_tdata[12];
      req_valid_in    = req_take ? 1'b1 : (step ? 1'b0 : req_valid_ff);
      rsp_valid_in    = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_in          = step ? rsp_next : rsp_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.rejected, rsp_ff.no_ack, rsp_ff.rx_data,
                        rsp_ff.done_res, rsp_ff.busy_res, rsp_ff.sda_drive,
                        rsp_ff.sda_level, rsp_ff.scl_level};

endmodule

`default_nettype wire

// ===== bench/i2c_master_bit_engine_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the I2C master bit engine: watches the req, rsp and csr ports,
// models the bus sequencer tick by tick and compares every rsp beat field by field.
// Depends on i2cm_pkg for phase codes, widths and phase lengths.

module i2c_master_bit_engine_checker
   import i2cm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // req beat: action[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero pad
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   // rsp beat: scl[0], sda[1], drive[2], busy[3], done[4], rx_data[12:5], no_ack[13],
   // rejected[14], zero pad
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               mismatches,
   output int               outstanding,
   output logic             last_busy
);

   // register copies
   logic [UNIT_W-1:0]    unit_ticks;
   logic [POLL_W-1:0]    poll_limit;

   // sequencer state
   phase_type            ph;
   logic [UNIT_W-1:0]    tick_cnt;
   logic [UNITS_W-1:0]   units_left;
   logic [BIT_IDX_W-1:0] bit_idx;
   logic [BYTE_BITS-1:0] shreg;
   logic [POLL_W-1:0]    polls_seen;
   logic                 scl_q, sda_q, drv_q;
   logic                 nack_q, ack_q, done_q;
   logic [BYTE_BITS-1:0] rx_q;

   rsp_type              line_expect_q[$];
   int                   miss_cnt = 0;

   task report_mismatch(input string what);
      $display("%0t: %s", $time, what);
      miss_cnt++;
   endtask

   task check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want)
         report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
   endtask

   task reset_model();
      unit_ticks = DELAY_UNIT_RESET;
      poll_limit = ACK_POLLS_RESET;
      ph         = PH_IDLE;
      tick_cnt   = '0;
      units_left = '0;
      bit_idx    = '0;
      shreg      = '0;
      polls_seen = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      drv_q      = 1'b1;
      nack_q     = 1'b0;
      ack_q      = 1'b0;
      done_q     = 1'b0;
      rx_q       = '0;
   endtask

   task enter_phase(input phase_type p, input logic [UNITS_W-1:0] n);
      ph         = p;
      units_left = n;
      tick_cnt   = '0;
   endtask

   task finish_cmd();
      enter_phase(PH_IDLE, '0);
      done_q = 1'b1;
   endtask

   // MSB goes out first
   task shift_out_bit();
      sda_q = shreg[BYTE_BITS-1];
      shreg = {shreg[BYTE_BITS-2:0], 1'b0};
   endtask

   // one busy tick: count ticks into units, units into phases
   task run_phase(input logic sda);
      logic [UNIT_W-1:0] lim;
      lim = (unit_ticks == '0) ? 16'd1 : unit_ticks;
      if (ph == PH_STOP_PRE) begin
         // one-tick prelude, then SCL rises
         scl_q = 1'b1;
         enter_phase(PH_STOP_A, STOP_UNITS);
      end else begin
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= lim) begin
            tick_cnt = '0;
            if (units_left != '0) units_left = units_left - 1'b1;
            if (units_left == '0) begin
               case (ph)
                  PH_START_A: begin
                     sda_q = 1'b0;
                     enter_phase(PH_START_B, START_B_UNITS);
                  end
                  PH_START_B: begin
                     scl_q = 1'b0;
                     finish_cmd();
                  end
                  PH_STOP_A: begin
                     sda_q = 1'b1;
                     enter_phase(PH_STOP_B, STOP_UNITS);
                  end
                  PH_STOP_B: finish_cmd();
                  PH_WR_SET: begin
                     scl_q = 1'b1;
                     enter_phase(PH_WR_HIGH, WR_UNITS);
                  end
                  PH_WR_HIGH: begin
                     scl_q = 1'b0;
                     enter_phase(PH_WR_LOW, WR_UNITS);
                  end
                  PH_WR_LOW: begin
                     bit_idx = bit_idx + 1'b1;
                     if (bit_idx >= BYTE_BITS) begin
                        finish_cmd();
                     end else begin
                        shift_out_bit();
                        enter_phase(PH_WR_SET, WR_UNITS);
                     end
                  end
                  PH_RD_LOW: begin
                     // sample on the rising SCL tick
                     scl_q = 1'b1;
                     shreg = {shreg[BYTE_BITS-2:0], sda};
                     enter_phase(PH_RD_HIGH, RD_HIGH_UNITS);
                  end
                  PH_RD_HIGH: begin
                     bit_idx = bit_idx + 1'b1;
                     scl_q   = 1'b0;
                     if (bit_idx < BYTE_BITS) begin
                        enter_phase(PH_RD_LOW, RD_LOW_UNITS);
                     end else begin
                        rx_q  = shreg;
                        drv_q = 1'b1;
                        sda_q = !ack_q;
                        enter_phase(PH_ACK_LOW, ACK_LOW_UNITS);
                     end
                  end
                  PH_ACK_LOW: begin
                     scl_q = 1'b1;
                     enter_phase(PH_ACK_HIGH, ACK_HIGH_UNITS);
                  end
                  PH_ACK_HIGH: begin
                     scl_q = 1'b0;
                     finish_cmd();
                  end
                  PH_WA_LOW: begin
                     scl_q = 1'b1;
                     enter_phase(PH_WA_HIGH, WA_UNITS);
                  end
                  PH_WA_HIGH: begin
                     if (!sda) begin
                        scl_q = 1'b0;
                        finish_cmd();
                     end else begin
                        if (polls_seen < POLL_MAX) polls_seen = polls_seen + 1'b1;
                        if (polls_seen >= poll_limit) begin
                           // give up: flag and run a stop
                           nack_q = 1'b1;
                           drv_q  = 1'b1;
                           scl_q  = 1'b0;
                           sda_q  = 1'b0;
                           enter_phase(PH_STOP_PRE, '0);
                        end else begin
                           enter_phase(PH_WA_HIGH, WA_UNITS);
                        end
                     end
                  end
                  default: enter_phase(PH_IDLE, '0);
               endcase
            end
         end
      end
   endtask

   // line levels and flags after one accepted req beat
   task step_bus_tick(input logic [15:0] beat, output rsp_type r);
      logic [2:0] act;
      logic       rej;
      act    = beat[2:0];
      rej    = 1'b0;
      done_q = 1'b0;
      if (ph != PH_IDLE) begin
         rej = (act >= ACT_START) && (act <= ACT_WACK);
         run_phase(beat[12]);
      end else begin
         case (act)
            ACT_START: begin
               drv_q = 1'b1;
               sda_q = 1'b1;
               scl_q = 1'b1;
               enter_phase(PH_START_A, START_A_UNITS);
            end
            ACT_STOP: begin
               drv_q = 1'b1;
               scl_q = 1'b0;
               sda_q = 1'b0;
               enter_phase(PH_STOP_PRE, '0);
            end
            ACT_WRITE: begin
               drv_q   = 1'b1;
               scl_q   = 1'b0;
               bit_idx = '0;
               shreg   = beat[10:3];
               shift_out_bit();
               enter_phase(PH_WR_SET, WR_UNITS);
            end
            ACT_READ: begin
               drv_q   = 1'b0;
               scl_q   = 1'b0;
               bit_idx = '0;
               shreg   = '0;
               ack_q   = beat[11];
               enter_phase(PH_RD_LOW, RD_LOW_UNITS);
            end
            ACT_WACK: begin
               drv_q      = 1'b0;
               sda_q      = 1'b1;
               polls_seen = '0;
               nack_q     = 1'b0;
               enter_phase(PH_WA_LOW, WA_UNITS);
            end
            default: ;
         endcase
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.sda_drive = drv_q;
      r.busy_res  = (ph != PH_IDLE);
      r.done_res  = done_q;
      r.rx_data   = rx_q;
      r.no_ack    = nack_q;
      r.rejected  = rej;
   endtask

   task compare_lines(input rsp_type want, input logic [15:0] got);
      check_field("scl_level", want.scl_level, got[0]);
      check_field("sda_level", want.sda_level, got[1]);
      check_field("sda_drive", want.sda_drive, got[2]);
      check_field("busy_res", want.busy_res, got[3]);
      check_field("done_res", want.done_res, got[4]);
      check_field("rx_data", want.rx_data, got[12:5]);
      check_field("no_ack", want.no_ack, got[13]);
      check_field("rejected", want.rejected, got[14]);
   endtask

   // monitor: csr writes, rsp beats against the oldest expectation, req beats
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         reset_model();
         line_expect_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_DELAY_UNIT) unit_ticks = csr_pwdata[UNIT_W-1:0];
            else poll_limit = csr_pwdata[POLL_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (line_expect_q.size() == 0) begin
               report_mismatch("rsp beat with nothing pending");
            end else begin
               want = line_expect_q.pop_front();
               compare_lines(want, rsp_tdata);
            end
            last_busy <= rsp_tdata[3];
         end
         if (req_tvalid && req_tready) begin
            step_bus_tick(req_tdata, fresh);
            line_expect_q.push_back(fresh);
         end
      end
      mismatches  <= miss_cnt;
      outstanding <= line_expect_q.size();
   end

endmodule

// ===== bench/i2c_master_bit_engine_tb.sv =====
`timescale 1ns / 100ps
// Top of the I2C master bit engine bench: clock, reset, req/rsp/csr stimulus and verdict.
// Depends on i2cm_pkg, i2c_master_bit_engine and i2c_master_bit_engine_checker.

module i2c_master_bit_engine_tb;
   import i2cm_pkg::*;

   // spare action codes, ignored by the engine
   localparam logic [2:0] ACT_SPARE6 = 3'd6;
   localparam logic [2:0] ACT_SPARE7 = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [15:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [15:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   int          mismatches;
   int          outstanding;
   logic        last_busy;

   // calm: no idling on either side; squeeze: one long rsp hold-off
   logic        calm = 1'b0;
   logic        squeeze = 1'b0;

   logic [UNIT_W-1:0] unit_set = DELAY_UNIT_RESET;
   logic [POLL_W-1:0] poll_set = ACK_POLLS_RESET;
   int                items_sent = 0;

   i2c_master_bit_engine dut (.*);

   i2c_master_bit_engine_checker line_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("i2c_master_bit_engine verification failed");
      $finish;
   end

   // rsp side: random stalls, one long hold-off
   initial begin : rsp_side
      bit squeezed;
      squeezed = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (squeeze && !squeezed) begin
            squeezed = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 23);
         end
      end
   end

   task csr_write(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == REG_DELAY_UNIT) unit_set = value[UNIT_W-1:0];
      else poll_set = value[POLL_W-1:0];
   endtask

   task set_config(input logic [31:0] unit, input logic [31:0] polls);
      csr_write(REG_DELAY_UNIT, unit);
      csr_write(REG_ACK_POLLS, polls);
   endtask

   // one req beat = one bus tick, with random idle cycles ahead of it
   task send_beat(input logic [2:0] act, input logic [7:0] tx, input logic ack,
                  input logic sda);
      while (!calm && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, sda, ack, tx, act};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // stop offering and wait for every expected rsp beat, plus pipeline slack
   task settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // tick the engine until a delivered beat shows it idle
   task drain_engine();
      do begin
         send_beat(ACT_NONE, 8'h00, 1'b0, 1'b0);
         settle();
      end while (last_busy);
   endtask

   // rough tick count of a command at the current settings
   function automatic int est_ticks(input logic [2:0] act, input int hold);
      int lim;
      int pe;
      int nh;
      lim = (unit_set == 0) ? 1 : int'(unit_set);
      pe  = (poll_set == 0) ? 1 : int'(poll_set);
      case (act)
         ACT_START: return 11 * lim;           // 5 + 6 units
         ACT_STOP:  return 1 + 12 * lim;       // prelude tick, 6 + 6 units
         ACT_WRITE: return 48 * lim;           // 8 bits of 6 units
         ACT_READ:  return 31 * lim;           // 8 bits of 3 units, ack 7
         ACT_WACK: begin
            nh = hold / lim;
            if (nh >= pe) return (13 + pe) * lim + 1;   // timeout and stop
            return (2 + nh) * lim;
         end
         default:   return 0;
      endcase
   endfunction

   // command beat followed by filler ticks; hold < 0 gives random SDA, else SDA is
   // high for the first hold ticks and low after
   task run_command(input logic [2:0] act, input logic [7:0] tx, input logic ack,
                    input int hold, input bit noisy);
      int         fill;
      logic [2:0] a;
      logic       s;
      fill = est_ticks(act, hold) + $urandom_range(0, 3);
      if (noisy && $urandom_range(9) == 0) fill = $urandom_range(0, fill);
      send_beat(act, tx, ack, (hold < 0) ? 1'($urandom) : (hold > 0));
      for (int t = 1; t <= fill; t++) begin
         a = ACT_NONE;
         if (noisy && $urandom_range(99) < 4) a = 3'($urandom_range(1, 7));
         s = (hold < 0) ? 1'($urandom) : (t < hold);
         send_beat(a, 8'($urandom), 1'($urandom), s);
      end
   endtask

   // well-formed command sequences with random content, some noise
   task run_random_phase(input int budget);
      int         first;
      int         pick;
      int         hold;
      int         lim;
      int         pe;
      logic [2:0] act;
      first = items_sent;
      while (items_sent - first < budget) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            act = (pick < 2) ? ACT_NONE : (pick < 4 ? ACT_SPARE6 : ACT_SPARE7);
            send_beat(act, 8'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            hold = -1;
            if (pick < 20) act = ACT_START;
            else if (pick < 35) act = ACT_STOP;
            else if (pick < 60) act = ACT_WRITE;
            else if (pick < 80) act = ACT_READ;
            else act = ACT_WACK;
            if (act == ACT_WACK) begin
               lim  = (unit_set == 0) ? 1 : int'(unit_set);
               pe   = (poll_set == 0) ? 1 : int'(poll_set);
               hold = $urandom_range(0, lim * (pe + 3));
            end
            run_command(act, 8'($urandom), 1'($urandom), hold, 1'b1);
         end
      end
      drain_engine();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on settings: acknowledge seen at the first poll
      send_beat(ACT_NONE, 8'h00, 1'b0, 1'b1);
      run_command(ACT_WACK, 8'h00, 1'b0, 0, 1'b0);
      drain_engine();

      // shortest unit: every command and line extreme
      set_config(1, 1);
      send_beat(ACT_SPARE6, 8'hFF, 1'b1, 1'b1);
      send_beat(ACT_SPARE7, 8'hFF, 1'b1, 1'b1);
      send_beat(ACT_NONE, 8'h00, 1'b0, 1'b0);
      run_command(ACT_START, 8'h00, 1'b0, -1, 1'b0);
      run_command(ACT_WRITE, 8'h00, 1'b0, -1, 1'b0);
      run_command(ACT_WRITE, 8'hFF, 1'b1, -1, 1'b0);
      run_command(ACT_WRITE, 8'h80, 1'b0, -1, 1'b0);
      run_command(ACT_READ, 8'h00, 1'b1, 1_000_000, 1'b0);
      run_command(ACT_READ, 8'hFF, 1'b0, 0, 1'b0);
      run_command(ACT_WACK, 8'h00, 1'b0, 0, 1'b0);
      run_command(ACT_WACK, 8'h00, 1'b0, 1_000_000, 1'b0);   // times out, stop follows
      run_command(ACT_WACK, 8'h00, 1'b0, 0, 1'b0);           // clears no-ack
      run_command(ACT_STOP, 8'h00, 1'b0, -1, 1'b0);
      drain_engine();

      // every code while busy: 1..5 rejected, spare codes ignored
      send_beat(ACT_WRITE, 8'h3C, 1'b0, 1'b0);
      for (int a = 1; a < 8; a++) send_beat(3'(a), 8'hFF, 1'b1, 1'b1);
      drain_engine();

      // zero unit acts as one, zero timeout gives up at the first high poll
      set_config(0, 0);
      run_command(ACT_WACK, 8'h00, 1'b0, 1_000_000, 1'b0);
      run_command(ACT_START, 8'h00, 1'b0, -1, 1'b0);
      drain_engine();

      // longest timeout: poll count saturates
      set_config(1, 255);
      run_command(ACT_WACK, 8'h00, 1'b0, 1_000_000, 1'b0);
      run_command(ACT_WACK, 8'h00, 1'b0, 20, 1'b0);
      drain_engine();

      // random phases over several settings
      set_config(1, $urandom_range(1, 4));
      run_random_phase(120);
      set_config(2, $urandom_range(1, 6));
      squeeze <= 1'b1;
      run_random_phase(120);
      set_config(0, $urandom_range(0, 3));
      run_random_phase(120);
      set_config($urandom_range(1, 3), 255);
      run_random_phase(120);
      set_config(1, $urandom_range(1, 6));
      calm <= 1'b1;
      run_random_phase(120);
      calm <= 1'b0;
      set_config(3, $urandom_range(1, 6));
      run_random_phase(120);

      settle();
      if (mismatches == 0 && outstanding == 0) begin
         $display("i2c_master_bit_engine verification clean");
      end else begin
         $display("i2c_master_bit_engine verification failed");
      end
      $finish;
   end

endmodule
